// ===== hw/rtl/xtea_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package xtea_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned KEY_WORDS = 4;
    localparam int unsigned CFG_IDX_W = 8;

    localparam logic [WORD_W-1:0] DELTA = 32'h9E37_79B9;

    typedef logic [WORD_W-1:0] t_word;
    typedef t_word [KEY_WORDS-1:0] t_key;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_WORD0 = 8'd0,
        REG_KEY_WORD1 = 8'd1,
        REG_KEY_WORD2 = 8'd2,
        REG_KEY_WORD3 = 8'd3
    } t_reg_idx;

    typedef struct packed {
        t_word v0;
        t_word v1;
        logic  last;
    } t_beat;

    function automatic t_word mix(input t_word v);
        return ((v << 4) ^ (v >> 5)) + v;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/xtea_half_round.sv =====
`timescale 1ns / 1ps
`default_nettype none

module xtea_half_round
    import xtea_pkg::*;
#(
    parameter logic [31:0] SUM        = 32'h0000_0000,
    parameter bit          UPD_SECOND = 1'b1
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_beat i_beat,
    input  wire t_key  i_key,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_beat      o_beat
);

    // key word index is fixed by the round sum of this stage
    localparam logic [1:0] KEY_IDX = UPD_SECOND ? SUM[12:11] : SUM[1:0];

    logic  r_vld;
    t_beat r_beat;
    t_beat n_beat;
    t_word w_src;
    t_word w_dst;
    t_word w_term;

    assign o_ready = !r_vld || i_ready;

    always_comb begin
        w_src  = UPD_SECOND ? i_beat.v0 : i_beat.v1;
        w_dst  = UPD_SECOND ? i_beat.v1 : i_beat.v0;
        w_term = mix(w_src) ^ (SUM + i_key[KEY_IDX]);
        n_beat = i_beat;
        if (UPD_SECOND) begin
            n_beat.v1 = w_dst - w_term;
        end else begin
            n_beat.v0 = w_dst - w_term;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_beat <= n_beat;
        end
    end

    assign o_valid = r_vld;
    assign o_beat  = r_beat;

endmodule

`default_nettype wire

// ===== hw/rtl/xtea_block_decrypt_core.sv =====
// XTEA block decryptor. Each beat on the input channel carries one 64-bit
// ciphertext block as two words plus a last flag; each output beat
// carries the matching plaintext words and the same flag, in input order.
// The 128-bit key is held in four registers written through the config
// channel (index 0 to 3, other indexes are ignored); write them only while no
// block is in flight. One half-round sits in each pipeline stage, and a new
// block is taken every cycle unless every stage holds a block and the output
// is stalled. Each stage stalls only when it holds data that the next stage
// cannot take, so gaps in the pipeline fill while the output waits.
`timescale 1ns / 1ps
`default_nettype none

module xtea_block_decrypt_core
    import xtea_pkg::*;
#(
    parameter int unsigned ROUNDS = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [31:0]          i_cipher_first,
    input  wire logic [31:0]          i_cipher_second,
    input  wire logic                 i_last_block,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [31:0]               o_plain_first,
    output logic [31:0]               o_plain_second,
    output logic                      o_last_out,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]          i_cfg_data
);

    localparam int unsigned NSTAGE = 2 * ROUNDS;

    t_key  r_key;
    t_beat w_beat [NSTAGE+1];
    logic  w_vld  [NSTAGE+1];
    logic  w_rdy  [NSTAGE+1];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_KEY_WORD0: r_key[0] <= i_cfg_data;
                REG_KEY_WORD1: r_key[1] <= i_cfg_data;
                REG_KEY_WORD2: r_key[2] <= i_cfg_data;
                REG_KEY_WORD3: r_key[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_vld[0]       = i_valid;
    assign o_ready        = w_rdy[0];
    assign w_beat[0].v0   = i_cipher_first;
    assign w_beat[0].v1   = i_cipher_second;
    assign w_beat[0].last = i_last_block;

    for (genvar s = 0; s < NSTAGE; s++) begin : g_stage
        localparam int unsigned RND = s / 2;
        localparam logic [63:0] SUM_HI  = 64'(DELTA) * 64'(ROUNDS - RND);
        localparam logic [63:0] SUM_LO  = 64'(DELTA) * 64'(ROUNDS - RND - 1);
        localparam logic [31:0] SUM_STG = (s % 2 == 0) ? SUM_HI[31:0] : SUM_LO[31:0];

        xtea_half_round #(
            .SUM        (SUM_STG),
            .UPD_SECOND (s % 2 == 0)
        ) u_half (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_vld[s]),
            .o_ready (w_rdy[s]),
            .i_beat  (w_beat[s]),
            .i_key   (r_key),
            .o_valid (w_vld[s+1]),
            .i_ready (w_rdy[s+1]),
            .o_beat  (w_beat[s+1])
        );
    end

    assign w_rdy[NSTAGE]  = i_ready;
    assign o_valid        = w_vld[NSTAGE];
    assign o_plain_first  = w_beat[NSTAGE].v0;
    assign o_plain_second = w_beat[NSTAGE].v1;
    assign o_last_out     = w_beat[NSTAGE].last;

endmodule

`default_nettype wire

// ===== hw/rtl/xtea_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module xtea_checker #(
    parameter int unsigned ROUNDS = 32
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_valid,
    input wire logic o_ready,
    input wire logic o_valid,
    input wire logic i_ready,
    input wire logic [31:0] o_plain_first,
    input wire logic [31:0] o_plain_second,
    input wire logic o_last_out,
    input wire logic i_cfg_valid,
    input wire logic o_cfg_ready
);

    localparam int unsigned NSTAGE = 2 * ROUNDS;
    localparam int unsigned CNT_W  = $clog2(NSTAGE + 2);

    logic [CNT_W-1:0] r_inflight;
    logic             w_in_beat;
    logic             w_out_beat;

    assign w_in_beat  = i_valid && o_ready;
    assign w_out_beat = o_valid && i_ready;

    // blocks accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else if (w_in_beat && !w_out_beat) begin
            r_inflight <= r_inflight + 1'b1;
        end else if (w_out_beat && !w_in_beat) begin
            r_inflight <= r_inflight - 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_plain_first)
            && $stable(o_plain_second) && $stable(o_last_out))
        else $error("output beat changed while stalled");

    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_inflight != '0)
        else $error("output beat without an accepted input");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= CNT_W'(NSTAGE))
        else $error("more blocks in flight than pipeline stages");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight == CNT_W'(NSTAGE) && !i_ready |-> !o_ready)
        else $error("input taken while pipeline full and stalled");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("config write refused");

endmodule

bind xtea_block_decrypt_core xtea_checker #(.ROUNDS(ROUNDS)) u_xtea_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_ready         (o_ready),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_plain_first   (o_plain_first),
    .o_plain_second  (o_plain_second),
    .o_last_out      (o_last_out),
    .i_cfg_valid     (i_cfg_valid),
    .o_cfg_ready     (o_cfg_ready)
);

`default_nettype wire
